FILE: hw/rtl/fisr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and binary32 normalize/round helpers for the fast inverse
// square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

   localparam logic [31:0] RSQRT_MAGIC     = 32'h5f3759df;
   localparam logic [31:0] CANON_QNAN      = 32'h7fc00000;
   localparam logic [31:0] FP_HALF         = 32'h3f000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
   localparam logic [7:0]  EXP_MAX         = 8'hff;

   // Width of the working significand: leading one sits at the top bit.
   localparam int unsigned MW = 51;

   // Leading zero count of a working significand.
   function automatic logic [5:0] lzc51(input logic [MW-1:0] m);
      logic [5:0] n;
      logic       found;
      n     = 6'(MW);
      found = 1'b0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (!found && m[i]) begin
            n     = 6'(MW - 1 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Packs a normalized significand (leading one at the top bit) with biased
   // exponent be into binary32, rounding to nearest even. Handles gradual
   // underflow and overflow to infinity.
   function automatic logic [31:0] round_pack(input logic sgn,
                                              input logic signed [10:0] be,
                                              input logic [MW-1:0] mn);
      logic [6:0]    sh;
      logic [MW-1:0] m_ext;
      logic [MW-1:0] mask;
      logic          lost;
      logic [23:0]   mant;
      logic          g;
      logic          st;
      logic [7:0]    efield;
      logic [30:0]   mag;
      sh = 7'd0;
      if (be <= 11'sd0) begin
         if (be < -11'sd50) begin
            sh = 7'(MW);
         end else begin
            sh = 7'(11'sd1 - be);
         end
      end
      m_ext  = mn >> sh;
      mask   = ~({MW{1'b1}} << sh);
      lost   = |(mn & mask);
      mant   = m_ext[MW-1 -: 24];
      g      = m_ext[MW-25];
      st     = (|m_ext[MW-26:0]) | lost;
      efield = (be > 11'sd0) ? be[7:0] : 8'd0;
      mag    = {efield, mant[22:0]} + 31'(g & (st | mant[0]));
      if (be >= 11'sd255) begin
         mag = {EXP_MAX, 23'd0};
      end
      return {sgn, mag};
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fisr_fmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_fmul
// Two-stage binary32 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fisr_fmul
   import fisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] z
);

   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sgn;
   } flags_type;

   logic [7:0]  ea, eb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   flags_type   flags_in, flags_ff;
   logic [8:0]  esum_in, esum_ff;
   logic [47:0] prod_in, prod_ff;

   assign ea     = a[30:23];
   assign eb     = b[30:23];
   assign a_nan  = (ea == EXP_MAX) && (a[22:0] != 23'd0);
   assign b_nan  = (eb == EXP_MAX) && (b[22:0] != 23'd0);
   assign a_inf  = (ea == EXP_MAX) && (a[22:0] == 23'd0);
   assign b_inf  = (eb == EXP_MAX) && (b[22:0] == 23'd0);
   assign a_zero = a[30:0] == 31'd0;
   assign b_zero = b[30:0] == 31'd0;

   always_comb begin
      flags_in.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      flags_in.inf  = a_inf | b_inf;
      flags_in.zero = a_zero | b_zero;
      flags_in.sgn  = a[31] ^ b[31];
      esum_in = 9'((ea == 8'd0) ? 8'd1 : ea) + 9'((eb == 8'd0) ? 8'd1 : eb);
      prod_in = {24'd0, (ea != 8'd0), a[22:0]} * {24'd0, (eb != 8'd0), b[22:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= flags_in;
         esum_ff  <= esum_in;
         prod_ff  <= prod_in;
      end
   end

   logic [MW-1:0]     pw;
   logic [5:0]        lz;
   logic signed [10:0] be;
   logic [31:0]       z_in, z_ff;

   always_comb begin
      pw = {prod_ff, 3'd0};
      lz = lzc51(pw);
      be = signed'({2'b00, esum_ff}) - 11'sd126 - signed'({5'd0, lz});
      if (flags_ff.nan) begin
         z_in = CANON_QNAN;
      end else if (flags_ff.inf) begin
         z_in = {flags_ff.sgn, EXP_MAX, 23'd0};
      end else if (flags_ff.zero) begin
         z_in = {flags_ff.sgn, 31'd0};
      end else begin
         z_in = round_pack(flags_ff.sgn, be, pw << lz);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fisr_fadd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_fadd
// Two-stage binary32 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fisr_fadd
   import fisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] z
);

   typedef struct packed {
      logic nan;
      logic inf;
      logic inf_sgn;
      logic zero_sgn;
      logic sgn;
   } flags_type;

   logic [31:0]   big, sml;
   logic [7:0]    eb, es, eb_eff, es_eff, d;
   logic          a_nan, b_nan, a_inf, b_inf, sub;
   logic [MW-1:0] big_m, sml_full, sml_sh;
   logic          lost;
   flags_type     flags_in, flags_ff;
   logic [7:0]    ex_in, ex_ff;
   logic [MW-1:0] sum_in, sum_ff;

   assign a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
   assign b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
   assign a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
   assign b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
   assign sub   = a[31] ^ b[31];

   always_comb begin
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb       = big[30:23];
      es       = sml[30:23];
      eb_eff   = (eb == 8'd0) ? 8'd1 : eb;
      es_eff   = (es == 8'd0) ? 8'd1 : es;
      d        = eb_eff - es_eff;
      big_m    = {1'b0, (eb != 8'd0), big[22:0], 26'd0};
      sml_full = {1'b0, (es != 8'd0), sml[22:0], 26'd0};
      if (d >= 8'(MW)) begin
         sml_sh = '0;
         lost   = sml_full != '0;
      end else begin
         sml_sh = sml_full >> d;
         lost   = |(sml_full & ~({MW{1'b1}} << d));
      end
      sum_in = sub ? (big_m - (sml_sh | MW'(lost))) : (big_m + (sml_sh | MW'(lost)));
      ex_in  = eb_eff;
      flags_in.nan      = a_nan | b_nan | (a_inf & b_inf & sub);
      flags_in.inf      = a_inf | b_inf;
      flags_in.inf_sgn  = a_inf ? a[31] : b[31];
      flags_in.zero_sgn = sub ? 1'b0 : a[31];
      flags_in.sgn      = big[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= flags_in;
         ex_ff    <= ex_in;
         sum_ff   <= sum_in;
      end
   end

   logic [5:0]         lz;
   logic signed [10:0] be;
   logic [31:0]        z_in, z_ff;

   always_comb begin
      lz = lzc51(sum_ff);
      be = signed'({3'b000, ex_ff}) + 11'sd1 - signed'({5'd0, lz});
      if (flags_ff.nan) begin
         z_in = CANON_QNAN;
      end else if (flags_ff.inf) begin
         z_in = {flags_ff.inf_sgn, EXP_MAX, 23'd0};
      end else if (sum_ff == '0) begin
         z_in = {flags_ff.zero_sgn, 31'd0};
      end else begin
         z_in = round_pack(flags_ff.sgn, be, sum_ff << lz);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fast_inverse_square_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Bit-trick estimate of 1/sqrt(x) refined by one Newton step in binary32.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                Payload
//   req_      in         req_valid / req_ready    req_number_bits  [31:0]
//   rsp_      out        rsp_valid / rsp_ready    rsp_result_bits  [31:0]
//
// One transaction enters per cycle while the pipeline is not stalled.
// The pipeline is made of five floating-point units of two stages each
// (x*0.5, t=hx*y, t2=t*y, 1.5-t2, y*corr) plus the output register.
// The whole pipeline advances together; when the output holds an untaken
// result, every stage freezes and req_ready drops, so nothing is lost.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fast_inverse_square_root
   import fisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_number_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_result_bits
);

   localparam int unsigned LAT = 11;

   logic              en;
   logic [LAT-1:0]    valid_ff;
   logic [31:0]       y_ff [8];
   logic [31:0]       guess;
   logic [31:0]       half_x, t, t2, corr, r;
   logic [31:0]       result_in, result_ff;

   // The whole pipeline moves whenever the output slot is free or being taken.
   assign en        = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = en;

   // Initial estimate: magic constant minus the arithmetically halved pattern.
   assign guess = RSQRT_MAGIC - {req_number_bits[31], req_number_bits[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // The estimate y rides alongside the arithmetic until the last multiply.
   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= guess;
         for (int i = 1; i < 8; i++) begin
            y_ff[i] <= y_ff[i-1];
         end
      end
   end

   fisr_fmul u_half (.clock(clock), .en(en), .a(req_number_bits), .b(FP_HALF), .z(half_x));
   fisr_fmul u_t    (.clock(clock), .en(en), .a(half_x), .b(y_ff[1]), .z(t));
   fisr_fmul u_t2   (.clock(clock), .en(en), .a(t), .b(y_ff[3]), .z(t2));
   fisr_fadd u_corr (.clock(clock), .en(en), .a(FP_THREE_HALVES),
                     .b({~t2[31], t2[30:0]}), .z(corr));
   fisr_fmul u_r    (.clock(clock), .en(en), .a(y_ff[7]), .b(corr), .z(r));

   // Any NaN leaves as the canonical quiet NaN.
   always_comb begin
      if ((r[30:23] == EXP_MAX) && (r[22:0] != 23'd0)) begin
         result_in = CANON_QNAN;
      end else begin
         result_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = valid_ff[LAT-1];
   assign rsp_result_bits = result_ff;

   // A NaN result is always the canonical pattern.
   a_canon_nan : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_bits[30:23] == EXP_MAX) && (rsp_result_bits[22:0] != 23'd0))
      |-> (rsp_result_bits == CANON_QNAN))
      else $error("non-canonical NaN on result");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock) reset |=> (valid_ff == '0))
      else $error("valid bits survive reset");

   // A stall freezes every valid bit in the pipeline.
   a_stall_freeze : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

FILE: test/fast_inverse_square_root_tb.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root_tb
// Streams binary32 bit patterns through the inverse square root pipeline. A
// bit-exact software copy of the estimate and its Newton step predicts each
// result not typed in by hand, and every response transaction is compared in order.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_tb
   import fisr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_number_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_bits;

   // One row of the directed table. When known is set, the expected result
   // is typed in by hand; otherwise the predictor supplies it.
   typedef struct {
      logic [31:0] value;
      logic        known;
      logic [31:0] result;
   } stim_row_type;

   logic [31:0] pending_results[$];
   int          failures;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_request;
   logic        hold_active;

   fast_inverse_square_root u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_number_bits (req_number_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_bits (rsp_result_bits)
   );

   always #5 clock = ~clock;

   function automatic logic is_nan(input logic [31:0] f);
      return (f[30:23] == EXP_MAX) && (f[22:0] != 23'd0);
   endfunction

   // Rounds sig * 2^ex (sig nonzero) to binary32, nearest even, with gradual
   // underflow and overflow to infinity.
   function automatic logic [31:0] round_to_single(input logic sgn, input int ex,
                                                   input logic [63:0] sig);
      logic [63:0]  norm;
      logic [127:0] wide;
      int           be;
      int           sh;
      logic [23:0]  kept;
      logic         guard;
      logic         sticky;
      logic [30:0]  mag;
      norm = sig;
      while (!norm[63]) begin
         norm = norm << 1;
         ex   = ex - 1;
      end
      // The leading one now weighs 2^(ex+63).
      be = ex + 63 + 127;
      if (be >= 255) begin
         return {sgn, EXP_MAX, 23'd0};
      end
      sh = 40;
      if (be < 1) begin
         sh = 41 - be;
         be = 0;
      end
      if (sh > 127) begin
         sh = 127;
      end
      wide   = {norm, 64'd0} >> sh;
      kept   = wide[87:64];
      guard  = wide[63];
      sticky = |wide[62:0];
      mag    = {be[7:0], kept[22:0]} + 31'(guard & (sticky | kept[0]));
      if (mag[30:23] == EXP_MAX) begin
         mag = {EXP_MAX, 23'd0};
      end
      return {sgn, mag};
   endfunction

   function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sgn;
      logic [23:0] ma;
      logic [23:0] mb;
      int          ea;
      int          eb;
      sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) begin
         return CANON_QNAN;
      end
      if (a[30:23] == EXP_MAX || b[30:23] == EXP_MAX) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            return CANON_QNAN;
         end
         return {sgn, EXP_MAX, 23'd0};
      end
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
         return {sgn, 31'd0};
      end
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      ea = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
      eb = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
      return round_to_single(sgn, ea + eb, {16'd0, 48'(ma) * 48'(mb)});
   endfunction

   function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      logic [63:0] wa;
      logic [63:0] wb;
      logic [63:0] aligned;
      logic [63:0] total;
      int          ea;
      int          eb;
      int          de;
      if (is_nan(a) || is_nan(b)) begin
         return CANON_QNAN;
      end
      if (a[30:23] == EXP_MAX) begin
         if (b[30:23] == EXP_MAX && a[31] != b[31]) begin
            return CANON_QNAN;
         end
         return a;
      end
      if (b[30:23] == EXP_MAX) begin
         return b;
      end
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
         return {a[31] & b[31], 31'd0};
      end
      if (a[30:0] == 31'd0) begin
         return b;
      end
      if (b[30:0] == 31'd0) begin
         return a;
      end
      big = (b[30:0] > a[30:0]) ? b : a;
      sml = (b[30:0] > a[30:0]) ? a : b;
      ea  = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
      eb  = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
      de  = ea - eb;
      wa  = {2'd0, big[30:23] != 8'd0, big[22:0], 38'd0};
      wb  = {2'd0, sml[30:23] != 8'd0, sml[22:0], 38'd0};
      // Bits shifted out of the smaller operand collapse into a sticky bit.
      if (de >= 64) begin
         aligned = 64'(|wb);
      end else if (de == 0) begin
         aligned = wb;
      end else begin
         aligned = (wb >> de) | 64'(|(wb << (64 - de)));
      end
      total = (big[31] == sml[31]) ? wa + aligned : wa - aligned;
      if (total == 64'd0) begin
         return 32'd0;
      end
      return round_to_single(big[31], ea - 188, total);
   endfunction

   // Magic-constant estimate followed by one Newton step, all in binary32.
   function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
      logic [31:0] half_x;
      logic [31:0] guess;
      logic [31:0] t;
      logic [31:0] t2;
      logic [31:0] corr;
      logic [31:0] r;
      half_x = single_mul(x, FP_HALF);
      guess  = RSQRT_MAGIC - {x[31], x[31:1]};
      t      = single_mul(half_x, guess);
      t2     = single_mul(t, guess);
      corr   = single_add(FP_THREE_HALVES, {~t2[31], t2[30:0]});
      r      = single_mul(guess, corr);
      return is_nan(r) ? CANON_QNAN : r;
   endfunction

   // Offers one transaction and waits for it to be taken. The valid is only
   // lowered when an idle gap follows, so it never toggles within one step.
   task automatic send_number(input logic [31:0] value, input logic known,
                              input logic [31:0] result);
      req_valid       <= 1'b1;
      req_number_bits <= value;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_results.push_back(known ? result : predict_rsqrt(value));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_number();
      case ($urandom_range(9))
         0: return $urandom & 32'h807fffff;                          // subnormal or zero
         1: return {1'($urandom), EXP_MAX, 23'($urandom_range(1))}; // inf or tiny NaN
         2: return {1'($urandom), EXP_MAX, 23'($urandom)};          // NaN mostly
         3, 4: return {1'b1, 31'($urandom)};                        // negative input
         5: return {1'b0, 8'($urandom_range(100, 154)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Response checker: the oldest expectation must match each result taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_result_bits);
            failures = failures + 1;
         end else begin
            if (rsp_result_bits !== pending_results[0]) begin
               $display("%0t: result_bits mismatch, expected %h actual %h",
                        $time, pending_results[0], rsp_result_bits);
               failures = failures + 1;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   // Receiver. A long hold-off is counted here in cycles while the sender
   // keeps offering, so the pipeline fills up and drops req_ready.
   always @(posedge clock) begin
      if (hold_request && !hold_active) begin
         hold_active <= 1'b1;
         rsp_ready   <= 1'b0;
         for (int n = 0; n < 200; n++) begin
            @(posedge clock);
         end
         hold_active <= 1'b0;
         rsp_ready   <= 1'b1;
      end else if (!hold_active) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      stim_row_type directed[$];
      logic [31:0] value;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_number_bits = 32'd0;
      rsp_ready       = 1'b0;
      failures        = 0;
      send_idle_pct   = 32;
      recv_idle_pct   = 67;
      hold_request    = 1'b0;
      hold_active     = 1'b0;

      // Extremes, signed zeros, infinities, NaNs with any payload or sign,
      // subnormals and the negative inputs whose shift copies the sign bit.
      directed = '{
         '{32'h7f800000, 1'b1, 32'hff800000},
         '{32'h7fc00000, 1'b1, CANON_QNAN},
         '{32'hffffffff, 1'b1, CANON_QNAN},
         '{32'h7f800001, 1'b1, CANON_QNAN},
         '{32'hff800000, 1'b0, 32'd0},
         '{32'h00000000, 1'b0, 32'd0},
         '{32'h80000000, 1'b0, 32'd0},
         '{32'h00000001, 1'b0, 32'd0},
         '{32'h007fffff, 1'b0, 32'd0},
         '{32'h807fffff, 1'b0, 32'd0},
         '{32'h00800000, 1'b0, 32'd0},
         '{32'h3f800000, 1'b0, 32'd0},
         '{32'h40800000, 1'b0, 32'd0},
         '{32'h7f7fffff, 1'b0, 32'd0},
         '{32'hbf800000, 1'b0, 32'd0},
         '{32'h5f3759df, 1'b0, 32'd0},
         '{32'haaaaaaaa, 1'b0, 32'd0},
         '{32'h55555555, 1'b0, 32'd0},
         '{32'hfffffffe, 1'b0, 32'd0},
         '{32'h3e800000, 1'b0, 32'd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_number(directed[i].value, directed[i].known, directed[i].result);
      end

      // Sender pauses until the pipeline has drained completely.
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      @(posedge clock);

      for (int i = 0; i < 480; i++) begin
         if (i == 160) begin
            send_idle_pct = 67;
            recv_idle_pct = 32;
         end
         if (i == 320) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i == 340) begin
            hold_request <= 1'b1;
         end
         if (i == 341) begin
            hold_request <= 1'b0;
         end
         value = random_number();
         send_number(value, 1'b0, 32'd0);
      end
      req_valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
